// File: hw/rtl/lpr_pkg.sv
// Shared types and constants for the LRU page replacement block.
package lpr_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int MAX_FRAMES_DEF = 8;
    localparam int PAGE_BITS_DEF  = 16;

    // Fixed field widths.
    localparam int FRAMES_W   = 4;
    localparam int COUNT_W    = 16;
    localparam int SLOT_OUT_W = 3;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // Register map: the word select bit of paddr picks the register.
    localparam logic REG_FRAMES_IN_USE = 1'b0;

    // Reset value of the frame count register.
    localparam logic [FRAMES_W-1:0] FRAMES_RESET = 4'd8;

    // Top of the saturating fault counter.
    localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                capture;
        logic                exec;
        logic                clear;
        logic [FRAMES_W-1:0] frames;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
    } t_dp_stat;

endpackage

// File: hw/rtl/lpr_dp.sv
// Datapath: frame table, recency ranks, fault counter and result register.
module lpr_dp #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lpr_pkg::t_dp_cmd              i_cmd,
    output lpr_pkg::t_dp_stat             o_stat,
    input  logic [PAGE_BITS-1:0]          i_page_number,
    input  logic                          i_end_of_string,
    output logic                          o_hit,
    output logic [lpr_pkg::SLOT_OUT_W-1:0] o_frame_slot,
    output logic                          o_evicted_valid,
    output logic [PAGE_BITS-1:0]          o_evicted_page,
    output logic [lpr_pkg::COUNT_W-1:0]   o_fault_count,
    output logic                          o_last_result
);
    import lpr_pkg::*;

    localparam int SW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int AW = 6;

    // Captured reference.
    logic [PAGE_BITS-1:0]  r_page;
    logic                  r_last;

    // Frame table and recency state.
    logic [PAGE_BITS-1:0]  r_pages [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] r_valid;
    logic [SW-1:0]         r_rank  [MAX_FRAMES];
    logic [COUNT_W-1:0]    r_faults;

    logic [AW-1:0]         eff;
    logic [MAX_FRAMES-1:0] act;
    logic [MAX_FRAMES-1:0] match;
    logic [MAX_FRAMES-1:0] empty;
    logic [MAX_FRAMES-1:0] oldest;
    logic                  hit;
    logic                  found;
    logic [SW-1:0]         hit_slot;
    logic [SW-1:0]         empty_slot;
    logic [SW-1:0]         lru_slot;
    logic [SW-1:0]         slot;
    logic [SW-1:0]         rank_s;
    logic [SW-1:0]         rank_top;
    logic                  evict;
    logic [COUNT_W-1:0]    n_faults;
    logic [SW-1:0]         n_rank  [MAX_FRAMES];

    // Clamp the frame count to 1..MAX_FRAMES and mark the active frames.
    always_comb begin
        if (i_cmd.frames == '0) begin
            eff = AW'(1);
        end else if (AW'(i_cmd.frames) > AW'(MAX_FRAMES)) begin
            eff = AW'(MAX_FRAMES);
        end else begin
            eff = AW'(i_cmd.frames);
        end
        rank_top = SW'(eff - AW'(1));
        for (int j = 0; j < MAX_FRAMES; j++) begin
            act[j]    = AW'(j) < eff;
            match[j]  = act[j] && r_valid[j] && (r_pages[j] == r_page);
            empty[j]  = act[j] && !r_valid[j];
            // With every active frame full the ranks are 0..k-1, so the
            // least recently used frame is the one holding rank k-1.
            oldest[j] = act[j] && (r_rank[j] == rank_top);
        end
    end

    // Lowest-numbered frame of each kind.
    always_comb begin
        hit_slot   = '0;
        empty_slot = '0;
        lru_slot   = '0;
        for (int j = MAX_FRAMES - 1; j >= 0; j--) begin
            if (match[j]) begin
                hit_slot = SW'(j);
            end
            if (empty[j]) begin
                empty_slot = SW'(j);
            end
            if (oldest[j]) begin
                lru_slot = SW'(j);
            end
        end
        hit   = |match;
        found = |empty;
    end

    // Slot choice, rank update and fault count.
    always_comb begin
        evict = !hit && !found;
        if (hit) begin
            slot = hit_slot;
        end else if (found) begin
            slot = empty_slot;
        end else begin
            slot = lru_slot;
        end
        rank_s = r_rank[hit_slot];
        for (int j = 0; j < MAX_FRAMES; j++) begin
            if (SW'(j) == slot) begin
                n_rank[j] = '0;
            end else if (act[j] && r_valid[j] && (!hit || (r_rank[j] < rank_s))) begin
                n_rank[j] = r_rank[j] + SW'(1);
            end else begin
                n_rank[j] = r_rank[j];
            end
        end
        if (!hit && (r_faults != COUNT_TOP)) begin
            n_faults = r_faults + COUNT_W'(1);
        end else begin
            n_faults = r_faults;
        end
    end

    // Capture the reference on an input transfer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_page <= i_page_number;
            r_last <= i_end_of_string;
        end
    end

    // Control state of the frame table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear || (i_cmd.exec && r_last)) begin
            r_valid  <= '0;
            r_faults <= '0;
            for (int j = 0; j < MAX_FRAMES; j++) begin
                r_rank[j] <= '0;
            end
        end else if (i_cmd.exec) begin
            r_valid[slot] <= 1'b1;
            r_faults      <= n_faults;
            for (int j = 0; j < MAX_FRAMES; j++) begin
                r_rank[j] <= n_rank[j];
            end
        end
    end

    // Page storage; a frame's page is read only while the frame is valid.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && !hit) begin
            r_pages[slot] <= r_page;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_hit           <= hit;
            o_frame_slot    <= SLOT_OUT_W'(slot);
            o_evicted_valid <= evict;
            o_evicted_page  <= evict ? r_pages[slot] : '0;
            o_fault_count   <= n_faults;
            o_last_result   <= r_last;
        end
    end

    assign o_stat.empty = (r_valid == '0);

endmodule

// File: hw/rtl/lpr_ctrl.sv
// Controller: sequencing state machine, register port and result handshake.
module lpr_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpr_pkg::PADDR_W-1:0]   paddr,
    input  logic [lpr_pkg::PDATA_W-1:0]   pwdata,
    output logic [lpr_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output lpr_pkg::t_dp_cmd              o_cmd,
    input  lpr_pkg::t_dp_stat             i_stat
);
    import lpr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [FRAMES_W-1:0] r_frames;
    logic                out_free;
    logic                cfg_wr;

    // The result register can take a new result when empty or being drained.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign cfg_wr     = psel && penable && pwrite && pready && (paddr[2] == REG_FRAMES_IN_USE);

    // Commands to the datapath.
    always_comb begin
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec    = (r_state == S_EXEC) && out_free;
        o_cmd.clear   = cfg_wr;
        o_cmd.frames  = r_frames;
    end

    // Next state and result valid.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Frame count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= FRAMES_RESET;
        end else if (cfg_wr) begin
            r_frames <= pwdata[FRAMES_W-1:0];
        end
    end

    assign pready      = 1'b1;
    assign prdata      = PDATA_W'(r_frames);
    assign o_out_valid = r_out_valid;

    // An accepted transfer is always followed by the update step.
    a_capture_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_EXEC))
        else $error("update step did not follow an input transfer");

    // A register write leaves every frame empty.
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear |=> i_stat.empty)
        else $error("frames not empty after a register write");

    // A result appears only out of the update step.
    a_rise_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("result valid without an update step");

    // The update waits while the result register is held.
    a_exec_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && !out_free) |=> (r_state == S_EXEC))
        else $error("update step left while the result register was full");

endmodule

// File: hw/rtl/lru_page_replacement.sv
// LRU page replacement over a small fully associative frame set.
// A result is registered by the update step that follows its capture; output stalls delay it.
// Each reference takes a capture/update sequence over the frame table and the input stalls
// during the update; the next input is taken while a result waits in the output register.
// Reset (synchronous, active low) empties all frames, zeroes ranks and the fault count, and
// sets frames_in_use to 8; a register write or end-of-string result empties and zeroes alike.
module lru_page_replacement #(
    parameter int MAX_FRAMES = lpr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = lpr_pkg::PAGE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [PAGE_BITS-1:0]          i_page_number,
    input  logic                          i_end_of_string,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_hit,
    output logic [lpr_pkg::SLOT_OUT_W-1:0] o_frame_slot,
    output logic                          o_evicted_valid,
    output logic [PAGE_BITS-1:0]          o_evicted_page,
    output logic [lpr_pkg::COUNT_W-1:0]   o_fault_count,
    output logic                          o_last_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpr_pkg::PADDR_W-1:0]   paddr,
    input  logic [lpr_pkg::PDATA_W-1:0]   pwdata,
    output logic [lpr_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import lpr_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencing and register port.
    lpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // Frame table and result register.
    lpr_dp #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_page_number   (i_page_number),
        .i_end_of_string (i_end_of_string),
        .o_hit           (o_hit),
        .o_frame_slot    (o_frame_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_count   (o_fault_count),
        .o_last_result   (o_last_result)
    );

endmodule

// File: bench/lru_check_pkg.sv
// Result type and frame tracking scoreboard for the LRU page replacement bench.
package lru_check_pkg;

    localparam int FRAME_SLOTS = lpr_pkg::MAX_FRAMES_DEF;
    localparam int PAGE_W      = lpr_pkg::PAGE_BITS_DEF;

    // One lookup result as it leaves the block.
    typedef struct packed {
        logic                            hit;
        logic [lpr_pkg::SLOT_OUT_W-1:0]  slot;
        logic                            evicted_valid;
        logic [PAGE_W-1:0]               evicted_page;
        logic [lpr_pkg::COUNT_W-1:0]     fault_count;
        logic                            last;
    } lookup_result_t;

    // Tracks the resident pages and their recency, and holds the lookups still owed.
    class lru_frame_tracker;
        logic [PAGE_W-1:0]            resident_page[FRAME_SLOTS];
        bit                           resident[FRAME_SLOTS];
        int unsigned                  age[FRAME_SLOTS];
        logic [lpr_pkg::COUNT_W-1:0]  faults;
        logic [lpr_pkg::FRAMES_W-1:0] frame_count_reg;
        lookup_result_t               owed_lookups[$];
        int                           mismatches;

        function new();
            frame_count_reg = lpr_pkg::FRAMES_RESET;
            mismatches = 0;
            empty_all();
        endfunction

        // Empty every frame and restart the fault count.
        function void empty_all();
            for (int j = 0; j < FRAME_SLOTS; j++) begin
                resident_page[j] = '0;
                resident[j] = 1'b0;
                age[j] = 0;
            end
            faults = '0;
        endfunction

        // A register write starts a new reference string.
        function void write_frame_count(logic [lpr_pkg::FRAMES_W-1:0] value);
            frame_count_reg = value;
            empty_all();
        endfunction

        // Out-of-range counts are clamped to 1..FRAME_SLOTS.
        function int unsigned active_frames();
            if (frame_count_reg == 0) return 1;
            if (frame_count_reg > FRAME_SLOTS) return FRAME_SLOTS;
            return frame_count_reg;
        endfunction

        // Make frame s the most recent; a fresh fill ages every other resident frame.
        function void make_recent(int unsigned s, int unsigned n, bit fresh);
            for (int unsigned j = 0; j < n; j++) begin
                if (j != s && resident[j] && (fresh || age[j] < age[s]))
                    age[j] = age[j] + 1;
            end
            age[s] = 0;
        endfunction

        // Predict the lookup for an accepted reference transfer.
        function void note_reference(logic [PAGE_W-1:0] page, logic eos);
            int unsigned    n;
            int unsigned    slot;
            int unsigned    oldest;
            bit             found;
            lookup_result_t r;
            n = active_frames();
            slot = 0;
            found = 1'b0;
            r = '0;
            for (int unsigned j = 0; j < n; j++) begin
                if (!found && resident[j] && resident_page[j] == page) begin
                    slot = j;
                    found = 1'b1;
                end
            end
            if (found) begin
                r.hit = 1'b1;
                make_recent(slot, n, 1'b0);
            end else begin
                // Lowest empty frame first, otherwise the least recently used one.
                for (int unsigned j = 0; j < n; j++) begin
                    if (!found && !resident[j]) begin
                        slot = j;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    oldest = 0;
                    slot = 0;
                    for (int unsigned j = 0; j < n; j++) begin
                        if (age[j] > oldest) begin
                            oldest = age[j];
                            slot = j;
                        end
                    end
                    r.evicted_valid = 1'b1;
                    r.evicted_page = resident_page[slot];
                end
                resident_page[slot] = page;
                resident[slot] = 1'b1;
                make_recent(slot, n, 1'b1);
                if (faults != lpr_pkg::COUNT_TOP) faults = faults + 1'b1;
            end
            r.slot = slot[lpr_pkg::SLOT_OUT_W-1:0];
            r.fault_count = faults;
            r.last = eos;
            owed_lookups.push_back(r);
            if (eos) empty_all();
        endfunction

        // Compare a lookup result transfer with the oldest one owed.
        function void check_result(lookup_result_t got);
            lookup_result_t want;
            bit             bad;
            if (owed_lookups.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected lookup result: hit=%0d slot=%0d count=%0d",
                             got.hit, got.slot, got.fault_count);
                return;
            end
            want = owed_lookups.pop_front();
            bad = (got.hit !== want.hit) || (got.slot !== want.slot)
                || (got.evicted_valid !== want.evicted_valid)
                || (got.evicted_page !== want.evicted_page)
                || (got.fault_count !== want.fault_count) || (got.last !== want.last);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Lookup mismatch, expected hit=%0d slot=%0d evict=%0d/%h count=%0d last=%0d",
                             want.hit, want.slot, want.evicted_valid, want.evicted_page,
                             want.fault_count, want.last);
                    $display("                 actual   hit=%0d slot=%0d evict=%0d/%h count=%0d last=%0d",
                             got.hit, got.slot, got.evicted_valid, got.evicted_page,
                             got.fault_count, got.last);
                end
            end
        endfunction

        function int owed_count();
            return owed_lookups.size();
        endfunction
    endclass

endpackage

// File: bench/tb.sv
// Top-level bench for the LRU page replacement block: directed and random runs.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lru_check_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    logic [PAGE_W-1:0]               i_page_number;
    logic                            i_end_of_string;
    logic                            o_out_valid;
    logic                            i_out_stall;
    logic                            o_hit;
    logic [lpr_pkg::SLOT_OUT_W-1:0]  o_frame_slot;
    logic                            o_evicted_valid;
    logic [PAGE_W-1:0]               o_evicted_page;
    logic [lpr_pkg::COUNT_W-1:0]     o_fault_count;
    logic                            o_last_result;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [lpr_pkg::PADDR_W-1:0]     paddr;
    logic [lpr_pkg::PDATA_W-1:0]     pwdata;
    logic [lpr_pkg::PDATA_W-1:0]     prdata;
    logic                            pready;

    lru_frame_tracker tracker;
    bit               send_gaps;
    bit               sink_stalls;
    int               stall_left;
    int unsigned      cycle_count;

    lru_page_replacement dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_page_number   (i_page_number),
        .i_end_of_string (i_end_of_string),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_hit           (o_hit),
        .o_frame_slot    (o_frame_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_count   (o_fault_count),
        .o_last_result   (o_last_result),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Output stall in random bursts while enabled.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 3);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Check every result transfer against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_result('{o_hit, o_frame_slot, o_evicted_valid, o_evicted_page,
                                   o_fault_count, o_last_result});
    end

    // Guard against a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Present one reference and hold it until the transfer happens.
    task automatic send_ref(logic [PAGE_W-1:0] page, logic eos);
        i_in_valid <= 1'b1;
        i_page_number <= page;
        i_end_of_string <= eos;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_reference(page, eos);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every owed lookup has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.owed_count() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write of the frame count: setup cycle, then access cycle.
    task automatic write_frame_count(logic [lpr_pkg::FRAMES_W-1:0] value);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= lpr_pkg::PADDR_W'({lpr_pkg::REG_FRAMES_IN_USE, 2'b00});
        pwdata <= lpr_pkg::PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.write_frame_count(value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // References drawn mostly from a small working set so hits and evictions both occur.
    task automatic random_refs(int count);
        logic [PAGE_W-1:0] base;
        int unsigned       spread;
        logic [PAGE_W-1:0] page;
        logic              eos;
        base = PAGE_W'($urandom);
        for (int k = 0; k < count; k++) begin
            spread = tracker.active_frames() + $urandom_range(0, 3);
            if ($urandom_range(0, 9) == 0)
                page = PAGE_W'($urandom);
            else
                page = base + PAGE_W'($urandom_range(0, spread - 1));
            eos = ($urandom_range(0, 39) == 0);
            send_ref(page, eos);
            if (eos) base = PAGE_W'($urandom);
        end
    endtask

    initial begin
        logic [lpr_pkg::FRAMES_W-1:0] phase_counts[7];
        tracker = new();
        cycle_count = 0;
        stall_left = 0;
        send_gaps = 1'b0;
        sink_stalls = 1'b0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_page_number <= '0;
        i_end_of_string <= 1'b0;
        i_out_stall <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: extreme pages, hits, fills, LRU evictions, end of string.
        send_ref(16'h0000, 1'b0);
        send_ref(16'hFFFF, 1'b0);
        send_ref(16'h0000, 1'b0);
        for (int p = 1; p <= 6; p++) send_ref(PAGE_W'(p), 1'b0);
        send_ref(16'h0007, 1'b0);
        send_ref(16'h0000, 1'b0);
        send_ref(16'h0008, 1'b0);
        send_ref(16'hFFFF, 1'b1);
        // A count of zero behaves as one frame.
        write_frame_count(4'd0);
        send_ref(16'h0005, 1'b0);
        send_ref(16'h0005, 1'b0);
        send_ref(16'h0006, 1'b0);
        send_ref(16'h0006, 1'b1);
        // A count above the frame total behaves as the full set.
        write_frame_count(4'd15);
        send_ref(16'hA5A5, 1'b0);
        send_ref(16'h5A5A, 1'b0);
        send_ref(16'hA5A5, 1'b1);

        // Random phases over several frame counts, the extremes among them.
        phase_counts = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3,
                         4'($urandom_range(2, 7)), 4'($urandom)};
        foreach (phase_counts[i]) begin
            send_gaps = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            write_frame_count(phase_counts[i]);
            random_refs(140);
        end

        // Closing stretch with no idling on either side.
        send_gaps = 1'b0;
        sink_stalls = 1'b0;
        write_frame_count(4'($urandom_range(1, 8)));
        random_refs(60);

        drain();
        repeat (10) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.owed_count() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
